### src/cps_pkg.sv
// Shared types, constants and character tables for the connection protocol sniffer.
package cps_pkg;

   localparam int PHRASE_LEN = 18;
   localparam int KW_COUNT   = 7;
   localparam int KW_MAXLEN  = 9;

   localparam logic [8*PHRASE_LEN-1:0] PHRASE = "Upgrade: websocket";

   localparam logic [7:0] RTMP_MARK = 8'h03;
   localparam logic [7:0] PRINT_LO  = 8'd32;
   localparam logic [7:0] PRINT_HI  = 8'd126;
   localparam logic [7:0] CHAR_SP   = 8'h20;
   localparam logic [7:0] CHAR_TAB  = 8'h09;
   localparam logic [7:0] CHAR_CR   = 8'h0D;
   localparam logic [7:0] CHAR_LF   = 8'h0A;

   // keyword bit positions
   localparam logic [KW_COUNT-1:0] KW_GET_MASK  = 7'b000_0001;
   localparam logic [KW_COUNT-1:0] KW_HTTP_MASK = 7'b000_1111;
   localparam logic [KW_COUNT-1:0] KW_RTSP_MASK = 7'b111_0000;
   localparam logic [KW_COUNT-1:0] KW_ALL_MASK  = 7'b111_1111;

   localparam logic [3:0] PREFIX_MAX = 4'd15;

   typedef enum logic [2:0] {
      PROTO_UNKNOWN   = 3'd0,
      PROTO_RTMP      = 3'd1,
      PROTO_HTTP      = 3'd2,
      PROTO_RTSP      = 3'd3,
      PROTO_WEBSOCKET = 3'd4
   } proto_type;

   // One accepted request as seen by the cells and the keyword tracker
   typedef struct packed {
      logic       take;    // a byte is carried
      logic       clear;   // end of buffer, return to reset state
      logic [7:0] data;
   } step_type;

   function automatic logic is_space(logic [7:0] c);
      is_space = (c == CHAR_SP) || (c == CHAR_TAB) || (c == CHAR_CR) || (c == CHAR_LF);
   endfunction

   function automatic logic is_printable(logic [7:0] c);
      is_printable = ((c >= PRINT_LO) && (c <= PRINT_HI)) ||
                     (c == CHAR_CR) || (c == CHAR_LF) || (c == CHAR_TAB);
   endfunction

   function automatic logic [7:0] phrase_char(logic [4:0] i);
      logic [7:0] sh;
      sh = {5'(PHRASE_LEN - 1) - i, 3'b000};
      phrase_char = 8'(PHRASE >> sh);
   endfunction

   function automatic logic [8*KW_MAXLEN-1:0] kw_text(logic [2:0] k);
      unique case (k)
         3'd0:    kw_text = (8*KW_MAXLEN)'("GET ");
         3'd1:    kw_text = (8*KW_MAXLEN)'("POST ");
         3'd2:    kw_text = (8*KW_MAXLEN)'("OPTIONS ");
         3'd3:    kw_text = (8*KW_MAXLEN)'("HEAD ");
         3'd4:    kw_text = (8*KW_MAXLEN)'("DESCRIBE ");
         3'd5:    kw_text = (8*KW_MAXLEN)'("SETUP ");
         3'd6:    kw_text = (8*KW_MAXLEN)'("PLAY ");
         default: kw_text = '0;
      endcase
   endfunction

   function automatic logic [3:0] kw_len(logic [2:0] k);
      unique case (k)
         3'd0:    kw_len = 4'd4;
         3'd1:    kw_len = 4'd5;
         3'd2:    kw_len = 4'd8;
         3'd3:    kw_len = 4'd5;
         3'd4:    kw_len = 4'd9;
         3'd5:    kw_len = 4'd6;
         3'd6:    kw_len = 4'd5;
         default: kw_len = 4'd0;
      endcase
   endfunction

   // character i of keyword k, counted from the left; zero past its end
   function automatic logic [7:0] kw_char(logic [2:0] k, logic [3:0] i);
      logic [8*KW_MAXLEN-1:0] text;
      logic [3:0]             len;
      logic [6:0]             sh;
      text = kw_text(k);
      len  = kw_len(k);
      sh   = {len - 4'd1 - i, 3'b000};
      if (i < len) begin
         kw_char = 8'(text >> sh);
      end else begin
         kw_char = 8'd0;
      end
   endfunction

endpackage

### src/connection_protocol_sniffer.sv
// Top level of the connection protocol sniffer: byte stream in, protocol code out.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------------------
//  req     | in        | req_tvalid/tready   | tdata[7:0] data_byte, tuser has_byte,
//          |           |                     | tlast last_byte
//  rsp     | out       | rsp_tvalid/tready   | tdata[2:0] protocol, tdata[7:3] zero
//
//  One request is taken per clock; every byte is finished in the cycle it is accepted.
//  A result appears in the output register in the cycle after the request carrying last.
//  The output register is the only buffer: requests are taken while it is empty or
//  being drained in the same cycle, so a stalled result holds off further requests.
//  Reset (synchronous, active high) clears all match state and drops any held result.
//  Phrase search runs through a row of 18 cells, one per phrase character, each cell
//  passing its hit bit to its right neighbor each byte.
module connection_protocol_sniffer
   import cps_pkg::*;
(
   input  logic       clock,
   input  logic       reset,

   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] data_byte
   input  logic       req_tuser,    // [0] has_byte
   input  logic       req_tlast,    // last_byte

   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata     // [2:0] protocol, [7:3] zero
);

   step_type            step;
   logic                req_accept;

   logic                seen_ff,      seen_in;
   logic                rtmp_ff,      rtmp_in;
   logic                printable_ff, printable_in;
   logic [KW_COUNT-1:0] kw_matched;
   logic                found;

   logic                rsp_valid_ff, rsp_valid_in;
   proto_type           proto_ff,     proto_in;

   logic [PHRASE_LEN-1:0] cell_hit_now;
   logic [PHRASE_LEN-1:0] cell_hit;

   // Accept whenever the output register is free or drains this cycle
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   assign step.take  = req_accept && req_tuser;
   assign step.clear = req_accept && req_tlast;
   assign step.data  = req_tdata;

   // Phrase search row: cell 0 always primed, last cell holds its hit
   for (genvar g = 0; g < PHRASE_LEN; g++) begin : g_cell
      cps_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .step     (step),
         .ch       (phrase_char(5'(g))),
         .prev_hit ((g == 0) ? 1'b1 : cell_hit[(g == 0) ? 0 : g - 1]),
         .sticky   (g == PHRASE_LEN - 1),
         .hit_now  (cell_hit_now[g]),
         .hit      (cell_hit[g])
      );
   end

   assign found = cell_hit[PHRASE_LEN-1] || cell_hit_now[PHRASE_LEN-1];

   cps_kw u_kw (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .matched_now (kw_matched)
   );

   // Per-buffer flags including the current byte
   always_comb begin
      seen_in      = seen_ff;
      rtmp_in      = rtmp_ff;
      printable_in = printable_ff;
      if (step.take) begin
         seen_in = 1'b1;
         if (!seen_ff) begin
            rtmp_in = (step.data == RTMP_MARK);
         end
         if (!is_printable(step.data)) begin
            printable_in = 1'b0;
         end
      end
   end

   // Classify in priority order: RTMP, WebSocket, HTTP keyword, RTSP keyword, printable
   always_comb begin
      priority if (!seen_in) begin
         proto_in = PROTO_UNKNOWN;
      end else if (rtmp_in) begin
         proto_in = PROTO_RTMP;
      end else if (((kw_matched & KW_GET_MASK) != '0) && found) begin
         proto_in = PROTO_WEBSOCKET;
      end else if ((kw_matched & KW_HTTP_MASK) != '0) begin
         proto_in = PROTO_HTTP;
      end else if ((kw_matched & KW_RTSP_MASK) != '0) begin
         proto_in = PROTO_RTSP;
      end else if (printable_in) begin
         proto_in = PROTO_HTTP;
      end else begin
         proto_in = PROTO_UNKNOWN;
      end
   end

   // Output register: load on end of buffer, drop when taken
   always_comb begin
      if (step.clear) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || step.clear) begin
         seen_ff      <= 1'b0;
         rtmp_ff      <= 1'b0;
         printable_ff <= 1'b1;
      end else begin
         seen_ff      <= seen_in;
         rtmp_ff      <= rtmp_in;
         printable_ff <= printable_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step.clear) begin
         proto_ff <= proto_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0_0000, proto_ff};

   // End of buffer always produces a result in the next cycle
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> rsp_tvalid)
      else $error("end of buffer did not produce a result");

   // A request without last never creates a result on its own
   a_no_spurious_result: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid && !(req_tvalid && req_tready && req_tlast)) |=> !rsp_tvalid)
      else $error("result appeared without end of buffer");

   // Protocol code stays in the defined range
   a_proto_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[2:0] <= PROTO_WEBSOCKET))
      else $error("protocol code out of range");

   // A lone 0x03 first byte that also ends the buffer classifies as RTMP
   a_rtmp_single: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast && req_tuser && !seen_ff &&
       (req_tdata == RTMP_MARK)) |=> (rsp_tdata[2:0] == PROTO_RTMP))
      else $error("single 0x03 byte not classified as RTMP");

   // Nothing is accepted while a held result is stalled
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("request taken while result stalled");

endmodule

### src/cps_cell.sv
// One phrase-search cell: matches one character of the upgrade phrase.
module cps_cell
   import cps_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  step_type   step,
   input  logic [7:0] ch,         // character this cell expects
   input  logic       prev_hit,   // left neighbor matched through the previous byte
   input  logic       sticky,     // hold the hit once set (last cell)
   output logic       hit_now,    // this byte completes the match through this cell
   output logic       hit
);

   logic hit_ff;
   logic hit_in;

   assign hit_now = step.take && prev_hit && (step.data == ch);

   always_comb begin
      if (step.clear) begin
         hit_in = 1'b0;
      end else if (step.take) begin
         hit_in = hit_now || (sticky && hit_ff);
      end else begin
         hit_in = hit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   assign hit = hit_ff;

endmodule

### src/cps_kw.sv
// Keyword prefix tracker: leading whitespace skip and per-keyword match state.
module cps_kw
   import cps_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  step_type            step,
   output logic [KW_COUNT-1:0] matched_now   // match flags including this byte
);

   logic                lead_ff,    lead_in;
   logic [3:0]          prefix_ff,  prefix_in;
   logic [KW_COUNT-1:0] alive_ff,   alive_in;
   logic [KW_COUNT-1:0] matched_ff, matched_in;

   always_comb begin
      lead_in    = lead_ff;
      prefix_in  = prefix_ff;
      alive_in   = alive_ff;
      matched_in = matched_ff;
      if (step.take && !(lead_ff && is_space(step.data))) begin
         lead_in = 1'b0;
         for (int k = 0; k < KW_COUNT; k++) begin
            if (alive_ff[k] && (prefix_ff < kw_len(3'(k)))) begin
               if (step.data != kw_char(3'(k), prefix_ff)) begin
                  alive_in[k] = 1'b0;
               end else if (prefix_ff + 4'd1 == kw_len(3'(k))) begin
                  matched_in[k] = 1'b1;
               end
            end
         end
         if (prefix_ff < PREFIX_MAX) begin
            prefix_in = prefix_ff + 4'd1;
         end
      end
   end

   assign matched_now = matched_in;

   always_ff @(posedge clock) begin
      if (reset || step.clear) begin
         lead_ff    <= 1'b1;
         prefix_ff  <= '0;
         alive_ff   <= KW_ALL_MASK;
         matched_ff <= '0;
      end else begin
         lead_ff    <= lead_in;
         prefix_ff  <= prefix_in;
         alive_ff   <= alive_in;
         matched_ff <= matched_in;
      end
   end

endmodule

### verif/tb_top.sv
// Self-checking testbench for the connection protocol sniffer.
`timescale 1ns / 1ps

module tb_top;
   import cps_pkg::*;

   // Keyword slots, in the order of the keyword bit vectors.
   typedef enum int {
      KEY_GET      = 0,
      KEY_POST     = 1,
      KEY_OPTIONS  = 2,
      KEY_HEAD     = 3,
      KEY_DESCRIBE = 4,
      KEY_SETUP    = 5,
      KEY_PLAY     = 6,
      KEY_COUNT    = 7
   } keyword_slot;

   // One request on the byte channel.
   typedef struct packed {
      logic [7:0] data;
      logic       has;
      logic       last;
   } byte_request;

   localparam logic [6:0] GET_KEYS       = 7'b000_0001;
   localparam logic [6:0] HTTP_KEYS      = 7'b000_1111;
   localparam logic [6:0] RTSP_KEYS      = 7'b111_0000;
   localparam logic [6:0] ALL_KEYS       = 7'b111_1111;
   localparam logic [7:0] RTMP_FIRST     = 8'h03;
   localparam logic [7:0] PRINTABLE_LO   = 8'd32;
   localparam logic [7:0] PRINTABLE_HI   = 8'd126;
   localparam logic [3:0] PREFIX_CEILING = 4'd15;
   localparam string      UPGRADE_TEXT   = "Upgrade: websocket";

   localparam int REQUEST_TARGET = 950;    // random part stops past this many requests
   localparam int BUFFER_TARGET  = 40;     // ... and once this many buffers are closed
   localparam int STEADY_FROM    = 300;    // no idling on either side in this window
   localparam int STEADY_TO      = 500;
   localparam int HOLDOFF_AT     = 700;    // receiver stops draining here
   localparam int HOLDOFF_LEN    = 400;
   localparam int DRAIN_CYCLES   = 10;
   localparam int CYCLE_LIMIT    = 200000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;

   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;   // [7:0] data_byte
   logic       req_tuser  = 1'b0;    // [0] has_byte
   logic       req_tlast  = 1'b0;    // last_byte

   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;            // [2:0] protocol, [7:3] zero

   connection_protocol_sniffer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------
   // Sniffer state as the predictor tracks it
   // ---------------------------------------------------------------
   logic       seen_first;
   logic       rtmp_mark;
   logic       leading_blank;
   logic [3:0] prefix_pos;
   logic [6:0] keys_alive;
   logic [6:0] keys_hit;
   logic [4:0] phrase_pos;
   logic       phrase_seen;
   logic       printable_only;

   proto_type   expected_protocols[$];
   byte_request pending_requests[$];

   int  requests_planned = 0;
   int  buffers_planned  = 0;
   int  requests_taken   = 0;
   int  error_count      = 0;
   int  cycle_count      = 0;
   int  holdoff_left     = 0;
   logic holdoff_done    = 1'b0;
   logic steady_phase;

   assign steady_phase = (requests_taken >= STEADY_FROM) && (requests_taken < STEADY_TO);

   function automatic string keyword_of(int k);
      case (k)
         KEY_GET:      return "GET ";
         KEY_POST:     return "POST ";
         KEY_OPTIONS:  return "OPTIONS ";
         KEY_HEAD:     return "HEAD ";
         KEY_DESCRIBE: return "DESCRIBE ";
         KEY_SETUP:    return "SETUP ";
         default:      return "PLAY ";
      endcase
   endfunction

   task automatic clear_sniff_state();
      seen_first     = 1'b0;
      rtmp_mark      = 1'b0;
      leading_blank  = 1'b1;
      prefix_pos     = '0;
      keys_alive     = ALL_KEYS;
      keys_hit       = '0;
      phrase_pos     = '0;
      phrase_seen    = 1'b0;
      printable_only = 1'b1;
   endtask

   // Priority order: RTMP marker, WebSocket upgrade, HTTP keyword, RTSP keyword,
   // plain printable text.
   function automatic proto_type protocol_verdict();
      if (!seen_first)                                  return PROTO_UNKNOWN;
      if (rtmp_mark)                                    return PROTO_RTMP;
      if ((keys_hit & GET_KEYS) != '0 && phrase_seen)   return PROTO_WEBSOCKET;
      if ((keys_hit & HTTP_KEYS) != '0)                 return PROTO_HTTP;
      if ((keys_hit & RTSP_KEYS) != '0)                 return PROTO_RTSP;
      if (printable_only)                               return PROTO_HTTP;
      return PROTO_UNKNOWN;
   endfunction

   // Advance the predicted state by one accepted request; queue a verdict on last.
   task automatic sniff_request(input logic [7:0] c, input logic has, input logic last);
      logic [4:0] next_pos;
      logic       blank;
      string      kw;
      if (has) begin
         if (!seen_first) begin
            seen_first = 1'b1;
            rtmp_mark  = (c == RTMP_FIRST);
         end
         if (!((c >= PRINTABLE_LO && c <= PRINTABLE_HI) || c == "\r" || c == "\n" ||
               c == "\t"))
            printable_only = 1'b0;

         // The phrase has a single 'U', at its head, so a miss restarts the search.
         if (!phrase_seen) begin
            if (phrase_pos < UPGRADE_TEXT.len() && c == UPGRADE_TEXT.getc(phrase_pos))
               next_pos = phrase_pos + 5'd1;
            else
               next_pos = (c == UPGRADE_TEXT.getc(0)) ? 5'd1 : 5'd0;
            if (next_pos >= UPGRADE_TEXT.len()) begin
               phrase_seen = 1'b1;
               next_pos    = 5'd0;
            end
            phrase_pos = next_pos;
         end

         blank = (c == " " || c == "\t" || c == "\r" || c == "\n");
         if (!(leading_blank && blank)) begin
            leading_blank = 1'b0;
            for (int k = 0; k < KEY_COUNT; k++) begin
               kw = keyword_of(k);
               if (keys_alive[k] && prefix_pos < kw.len()) begin
                  if (c != kw.getc(prefix_pos))
                     keys_alive[k] = 1'b0;
                  else if (prefix_pos + 1 == kw.len())
                     keys_hit[k] = 1'b1;
               end
            end
            if (prefix_pos < PREFIX_CEILING)
               prefix_pos = prefix_pos + 4'd1;
         end
      end
      if (last) begin
         expected_protocols.push_back(protocol_verdict());
         clear_sniff_state();
      end
   endtask

   // ---------------------------------------------------------------
   // Request builders
   // ---------------------------------------------------------------
   task automatic queue_request(input logic [7:0] data, input logic has, input logic last);
      byte_request r;
      r.data = data;
      r.has  = has;
      r.last = last;
      pending_requests.push_back(r);
      if (has || last)
         requests_planned++;
      if (last)
         buffers_planned++;
   endtask

   // Carry one byte; now and then slip in an empty request that the block must ignore.
   task automatic queue_byte(input logic [7:0] c);
      if ($urandom_range(19) == 0)
         queue_request(8'($urandom_range(255)), 1'b0, 1'b0);
      queue_request(c, 1'b1, 1'b0);
   endtask

   task automatic queue_text(input string s);
      for (int i = 0; i < s.len(); i++)
         queue_byte(s.getc(i));
   endtask

   task automatic queue_printable(input int n);
      repeat (n) queue_byte(8'($urandom_range(PRINTABLE_LO, PRINTABLE_HI)));
   endtask

   function automatic logic [7:0] pick_blank();
      case ($urandom_range(3))
         0:       return " ";
         1:       return "\t";
         2:       return "\r";
         default: return "\n";
      endcase
   endfunction

   // Close the buffer either on its final byte or with a separate byte-less request.
   task automatic close_buffer();
      if ($urandom_range(4) == 0) begin
         queue_request(8'($urandom_range(255)), 1'b0, 1'b1);
      end else begin
         pending_requests[pending_requests.size() - 1].last = 1'b1;
         buffers_planned++;
      end
   endtask

   // Leading blanks, a keyword (sometimes damaged), header text, maybe the upgrade phrase
   // (sometimes damaged or preceded by a stray 'U'), maybe a random byte, and a printable tail.
   task automatic queue_request_line(input int tail_len);
      string kw;
      string phrase;
      if ($urandom_range(3) == 0)
         repeat ($urandom_range(1, 3)) queue_byte(pick_blank());
      kw = keyword_of($urandom_range(KEY_COUNT - 1));
      if ($urandom_range(7) == 0)
         kw.putc($urandom_range(kw.len() - 1), 8'($urandom_range(PRINTABLE_LO, PRINTABLE_HI)));
      queue_text(kw);
      queue_printable($urandom_range(tail_len));
      if ($urandom_range(99) < 45) begin
         phrase = UPGRADE_TEXT;
         if ($urandom_range(3) == 0)
            queue_byte(UPGRADE_TEXT.getc(0));
         if ($urandom_range(4) == 0)
            phrase.putc($urandom_range(phrase.len() - 1),
                        8'($urandom_range(PRINTABLE_LO, PRINTABLE_HI)));
         queue_text(phrase);
         queue_text("\r\n");
      end
      if ($urandom_range(9) == 0)
         queue_byte(8'($urandom_range(255)));
      queue_printable($urandom_range(4));
   endtask

   task automatic queue_random_buffer();
      int kind;
      kind = $urandom_range(99);
      if (kind < 50) begin
         queue_request_line(10);
      end else if (kind < 60) begin
         queue_byte(RTMP_FIRST);
         repeat ($urandom_range(8)) queue_byte(8'($urandom_range(255)));
      end else if (kind < 70) begin
         // blank-only or plain printable text
         if ($urandom_range(1) == 0)
            repeat ($urandom_range(1, 6)) queue_byte(pick_blank());
         else
            queue_printable($urandom_range(1, 20));
      end else if (kind < 85) begin
         repeat ($urandom_range(1, 12)) queue_byte(8'($urandom_range(255)));
      end else if (kind < 90) begin
         // empty buffer
         queue_request(8'($urandom_range(255)), 1'b0, 1'b1);
         return;
      end else begin
         // long buffer: run the prefix counter into saturation
         queue_request_line(40);
         queue_printable($urandom_range(16, 30));
      end
      close_buffer();
   endtask

   // ---------------------------------------------------------------
   // Stimulus and end of run
   // ---------------------------------------------------------------
   initial begin
      clear_sniff_state();

      // Empty buffer, then an ignored request ahead of a lone RTMP marker.
      queue_request(8'h00, 1'b0, 1'b1);
      queue_request(8'hFF, 1'b0, 1'b0);
      queue_request(RTMP_FIRST, 1'b1, 1'b1);
      // Lowest and highest byte values: not printable, so unknown.
      queue_request(8'h00, 1'b1, 1'b1);
      queue_request(8'hFF, 1'b1, 1'b0);
      queue_request("A", 1'b1, 1'b1);
      // Blanks only: printable, so HTTP.
      queue_text(" \t\r\n");
      pending_requests[pending_requests.size() - 1].last = 1'b1;
      buffers_planned++;
      // RTSP keyword closed by a byte-less last request.
      queue_text("PLAY ");
      queue_request(8'h00, 1'b0, 1'b1);
      // OPTIONS resolves to HTTP.
      queue_text("OPTIONS ");
      pending_requests[pending_requests.size() - 1].last = 1'b1;
      buffers_planned++;

      while (requests_planned < REQUEST_TARGET || buffers_planned < BUFFER_TARGET)
         queue_random_buffer();

      // Hold reset for the first cycles only.
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Sample on the falling edge so the driver's updates have settled.
      @(negedge clock);
      while (pending_requests.size() != 0 || req_tvalid)
         @(negedge clock);
      while (expected_protocols.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (error_count == 0 && expected_protocols.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Stop a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("status: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Driver: predict each accepted request, then offer the next one
   // ---------------------------------------------------------------
   always @(posedge clock) begin : drive_requests
      byte_request next_req;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            sniff_request(req_tdata, req_tuser, req_tlast);
            requests_taken <= requests_taken + 1;
         end
         // Hold an offered request until it is taken; idle only between requests.
         if (!req_tvalid || req_tready) begin
            if (pending_requests.size() != 0 && (steady_phase || $urandom_range(99) >= 32)) begin
               next_req = pending_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_req.data;
               req_tuser  <= next_req.has;
               req_tlast  <= next_req.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Receiver: random stalls, one long hold-off that backs up the input
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (holdoff_left != 0) begin
         rsp_tready   <= 1'b0;
         holdoff_left <= holdoff_left - 1;
      end else if (!holdoff_done && requests_taken >= HOLDOFF_AT) begin
         rsp_tready   <= 1'b0;
         holdoff_left <= HOLDOFF_LEN;
         holdoff_done <= 1'b1;
      end else begin
         rsp_tready <= steady_phase || ($urandom_range(99) >= 32);
      end
   end

   task automatic flag_mismatch(input string msg);
      error_count++;
      if (error_count <= 10)
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
   endtask

   // ---------------------------------------------------------------
   // Monitor: compare each accepted result with the oldest expected verdict
   // ---------------------------------------------------------------
   always @(posedge clock) begin : check_results
      proto_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_protocols.size() == 0) begin
            flag_mismatch($sformatf("unexpected result, tdata 0x%02h", rsp_tdata));
         end else begin
            want = expected_protocols.pop_front();
            // Drop the padding into the same compare: it must read as zero.
            if (rsp_tdata !== {5'b0, want})
               flag_mismatch($sformatf("protocol expected %0d (%s), got tdata 0x%02h",
                                       want, want.name(), rsp_tdata));
         end
      end
   end

endmodule

### filelist.f
src/cps_pkg.sv
src/cps_cell.sv
src/cps_kw.sv
src/connection_protocol_sniffer.sv
verif/tb_top.sv
